// File: sv/mbc_pkg.sv
package mbc_pkg;

  // parameter defaults
  localparam int DEF_COORD_WIDTH = 48;
  localparam int DEF_FRAC_BITS   = 40;
  localparam int DEF_COUNT_WIDTH = 16;

  // fixed field widths
  localparam int ZOOM_W     = 47;
  localparam int OFF_W      = 48;
  localparam int SIZE_W     = 13;
  localparam int PIX_W      = 12;
  localparam int ITER_W     = 17;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 48;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ZOOM     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_X = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Y = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_ITER = 3'd5;

  // reset values
  localparam logic [ZOOM_W-1:0] RST_ZOOM     = 47'h0001_0000_0000;
  localparam logic [OFF_W-1:0]  RST_OFFSET   = '0;
  localparam logic [SIZE_W-1:0] RST_WIDTH    = 13'd640;
  localparam logic [SIZE_W-1:0] RST_HEIGHT   = 13'd480;
  localparam logic [ITER_W-1:0] RST_MAX_ITER = 17'd256;

  // multiply operations, in issue order within one step
  localparam int OP_W = 3;
  localparam logic [OP_W-1:0] OP_R2 = 3'd0;  // zr*zr
  localparam logic [OP_W-1:0] OP_I2 = 3'd1;  // zi*zi
  localparam logic [OP_W-1:0] OP_R3 = 3'd2;  // r2*zr
  localparam logic [OP_W-1:0] OP_I3 = 3'd3;  // i2*zi
  localparam logic [OP_W-1:0] OP_T1 = 3'd4;  // 3*r2*zi
  localparam logic [OP_W-1:0] OP_T2 = 3'd5;  // 3*zr*i2

  typedef struct packed {
    logic            load;       // capture pixel, arm start-point shift-add
    logic            sp_step;    // one shift-add step
    logic            sp_sum;     // offset - half size
    logic            sp_clamp;   // + pixel offset, clamp, seed z
    logic            mul_start;
    logic [OP_W-1:0] op;
    logic            mul_wr;     // store product for op
    logic            upd_diff;
    logic            upd_z;
  } mbc_cmd_t;

  typedef struct packed {
    logic mul_done;
    logic escape;
  } mbc_status_t;

endpackage

// File: sv/multibrot_cubic_escape_time_core.sv
// Sequence: the start point is formed by shift-add steps, a sum and a clamp; each full z^3+c step
// runs six products on one shared multiplier, with the escape check after the first two and the update after the last.
// Throughput: one pixel at a time; a new start is taken in the cycle the result strobes.
// Reset (rst_n low, synchronous) returns to idle and restores the configuration register defaults.
// The result strobe lasts one cycle; the receiver cannot stall it.
module multibrot_cubic_escape_time_core import mbc_pkg::*; #(
  parameter int COORD_WIDTH = DEF_COORD_WIDTH,
  parameter int FRAC_BITS   = DEF_FRAC_BITS,
  parameter int COUNT_WIDTH = DEF_COUNT_WIDTH
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  output logic                   busy,
  input  logic [PIX_W-1:0]       in_pixel_x,
  input  logic [PIX_W-1:0]       in_pixel_y,
  output logic                   out_valid,
  output logic [COUNT_WIDTH-1:0] out_iteration_count,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  logic [ZOOM_W-1:0] zoom_r;
  logic [OFF_W-1:0]  offset_x_r, offset_y_r;
  logic [SIZE_W-1:0] width_r, height_r;
  logic [ITER_W-1:0] max_iter_r;

  mbc_cmd_t    cmd;
  mbc_status_t status;
  logic        start_ok;

  assign cfg_ready = 1'b1;
  assign start_ok  = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      zoom_r     <= RST_ZOOM;
      offset_x_r <= RST_OFFSET;
      offset_y_r <= RST_OFFSET;
      width_r    <= RST_WIDTH;
      height_r   <= RST_HEIGHT;
      max_iter_r <= RST_MAX_ITER;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_ZOOM:     zoom_r     <= cfg_data[ZOOM_W-1:0];
        REG_OFFSET_X: offset_x_r <= cfg_data[OFF_W-1:0];
        REG_OFFSET_Y: offset_y_r <= cfg_data[OFF_W-1:0];
        REG_WIDTH:    width_r    <= cfg_data[SIZE_W-1:0];
        REG_HEIGHT:   height_r   <= cfg_data[SIZE_W-1:0];
        REG_MAX_ITER: max_iter_r <= cfg_data[ITER_W-1:0];
        default: ;
      endcase
    end
  end

  mbc_ctrl #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start_ok),
    .max_iter (max_iter_r),
    .status   (status),
    .cmd      (cmd),
    .busy     (busy),
    .out_valid(out_valid),
    .out_count(out_iteration_count)
  );

  mbc_datapath #(
    .COORD_WIDTH(COORD_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .status    (status),
    .pixel_x   (in_pixel_x),
    .pixel_y   (in_pixel_y),
    .zoom      (zoom_r),
    .offset_x  (offset_x_r),
    .offset_y  (offset_y_r),
    .pic_width (width_r),
    .pic_height(height_r)
  );

endmodule

// File: sv/mbc_mul.sv
module mbc_mul import mbc_pkg::*; #(
  parameter int COORD_WIDTH = DEF_COORD_WIDTH,
  parameter int FRAC_BITS   = DEF_FRAC_BITS
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic [COORD_WIDTH-1:0] a,
  input  logic [COORD_WIDTH-1:0] b,
  output logic                   done,
  output logic [COORD_WIDTH-1:0] p
);

  localparam int W  = COORD_WIDTH;
  localparam int H  = (W + 1) / 2;
  localparam int PW = 4 * H;

  localparam logic [2:0] MP_IDLE = 3'd0;
  localparam logic [2:0] MP_MAG  = 3'd1;
  localparam logic [2:0] MP_PP0  = 3'd2;
  localparam logic [2:0] MP_PP1  = 3'd3;
  localparam logic [2:0] MP_PP2  = 3'd4;
  localparam logic [2:0] MP_PP3  = 3'd5;
  localparam logic [2:0] MP_FIN  = 3'd6;

  localparam logic [W-1:0] CMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] CMIN = {1'b1, {(W-1){1'b0}}};

  logic [2:0]    ph_r, ph_nxt;
  logic [W-1:0]  a_r, b_r, ma_r, mb_r;
  logic          neg_r;
  logic [PW-1:0] acc_r;

  logic [H-1:0]   a_lo, a_hi, b_lo, b_hi, opa, opb;
  logic [2*H-1:0] pp;
  logic [PW-1:0]  pp_sh, m_w, lim_w;

  always_comb begin
    case (ph_r)
      MP_IDLE: ph_nxt = start ? MP_MAG : MP_IDLE;
      MP_MAG:  ph_nxt = MP_PP0;
      MP_PP0:  ph_nxt = MP_PP1;
      MP_PP1:  ph_nxt = MP_PP2;
      MP_PP2:  ph_nxt = MP_PP3;
      MP_PP3:  ph_nxt = MP_FIN;
      MP_FIN:  ph_nxt = MP_IDLE;
      default: ph_nxt = MP_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r <= MP_IDLE;
    end else begin
      ph_r <= ph_nxt;
    end
  end

  assign a_lo = ma_r[H-1:0];
  assign a_hi = H'(ma_r >> H);
  assign b_lo = mb_r[H-1:0];
  assign b_hi = H'(mb_r >> H);

  // one half-width partial product per cycle
  always_comb begin
    case (ph_r)
      MP_PP0:  begin opa = a_lo; opb = b_lo; end
      MP_PP1:  begin opa = a_lo; opb = b_hi; end
      MP_PP2:  begin opa = a_hi; opb = b_lo; end
      MP_PP3:  begin opa = a_hi; opb = b_hi; end
      default: begin opa = '0;   opb = '0;   end
    endcase
    pp = opa * opb;
    case (ph_r)
      MP_PP1, MP_PP2: pp_sh = PW'(pp) << H;
      MP_PP3:         pp_sh = PW'(pp) << (2 * H);
      default:        pp_sh = PW'(pp);
    endcase
  end

  always_ff @(posedge clk) begin
    if (start && ph_r == MP_IDLE) begin
      a_r <= a;
      b_r <= b;
    end
    if (ph_r == MP_MAG) begin
      ma_r  <= a_r[W-1] ? -a_r : a_r;
      mb_r  <= b_r[W-1] ? -b_r : b_r;
      neg_r <= a_r[W-1] ^ b_r[W-1];
      acc_r <= '0;
    end else if (ph_r == MP_PP0 || ph_r == MP_PP1 || ph_r == MP_PP2 || ph_r == MP_PP3) begin
      acc_r <= acc_r + pp_sh;
    end
  end

  // scale, saturate, restore sign
  always_comb begin
    m_w   = acc_r >> FRAC_BITS;
    lim_w = neg_r ? (PW'(1) << (W - 1)) : ((PW'(1) << (W - 1)) - PW'(1));
    if (m_w >= lim_w) begin
      p = neg_r ? CMIN : CMAX;
    end else begin
      p = neg_r ? -m_w[W-1:0] : m_w[W-1:0];
    end
  end

  assign done = (ph_r == MP_FIN);

endmodule

// File: sv/mbc_datapath.sv
module mbc_datapath import mbc_pkg::*; #(
  parameter int COORD_WIDTH = DEF_COORD_WIDTH,
  parameter int FRAC_BITS   = DEF_FRAC_BITS
) (
  input  logic              clk,
  input  logic              rst_n,
  input  mbc_cmd_t          cmd,
  output mbc_status_t       status,
  input  logic [PIX_W-1:0]  pixel_x,
  input  logic [PIX_W-1:0]  pixel_y,
  input  logic [ZOOM_W-1:0] zoom,
  input  logic [OFF_W-1:0]  offset_x,
  input  logic [OFF_W-1:0]  offset_y,
  input  logic [SIZE_W-1:0] pic_width,
  input  logic [SIZE_W-1:0] pic_height
);

  localparam int W    = COORD_WIDTH;
  localparam int ACCW = SIZE_W + ZOOM_W;
  localparam int SPW  = (ACCW + 2 > W) ? ACCW + 2 : W;
  localparam int EW   = (W + 1 > FRAC_BITS + 3) ? W + 1 : FRAC_BITS + 3;

  localparam logic [W-1:0]   CMAX   = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0]   CMIN   = {1'b1, {(W-1){1'b0}}};
  localparam logic [SPW-1:0] CMAX_E = {{(SPW-W+1){1'b0}}, {(W-1){1'b1}}};
  localparam logic [SPW-1:0] CMIN_E = ~CMAX_E;
  localparam logic [EW-1:0]  FOUR   = EW'(4) << FRAC_BITS;

  function automatic logic [W-1:0] sat_add(input logic [W-1:0] x, input logic [W-1:0] y);
    logic [W:0] s;
    s = {x[W-1], x} + {y[W-1], y};
    if (s[W] != s[W-1]) return s[W] ? CMIN : CMAX;
    return s[W-1:0];
  endfunction

  function automatic logic [W-1:0] sat_sub(input logic [W-1:0] x, input logic [W-1:0] y);
    logic [W:0] s;
    s = {x[W-1], x} - {y[W-1], y};
    if (s[W] != s[W-1]) return s[W] ? CMIN : CMAX;
    return s[W-1:0];
  endfunction

  // 3*x clamped; same as two chained saturating adds
  function automatic logic [W-1:0] triple(input logic [W-1:0] x);
    logic [W+1:0] s;
    s = {{2{x[W-1]}}, x} + {x[W-1], x, 1'b0};
    if (s[W+1:W-1] != 3'b000 && s[W+1:W-1] != 3'b111) return s[W+1] ? CMIN : CMAX;
    return s[W-1:0];
  endfunction

  logic [SIZE_W-1:0] sw_r, sh_r, sx_r, sy_r;
  logic [ACCW-1:0]   wz_r, hz_r, xz_r, yz_r;
  logic [SPW-1:0]    tx_r, ty_r, ux, uy;
  logic [W-1:0]      cr_r, ci_r, zr_r, zi_r;
  logic [W-1:0]      r2_r, i2_r, r3_r, i3_r, t1_r, t2_r, dr_r, di_r;
  logic [W-1:0]      cr_nxt, ci_nxt;
  logic [W-1:0]      mul_a, mul_b, mul_p;
  logic              mul_done;
  logic [EW-1:0]     mag2;

  // start point: size*zoom and pixel*zoom by MSB-first shift-add
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      sw_r <= pic_width;
      sh_r <= pic_height;
      sx_r <= SIZE_W'(pixel_x);
      sy_r <= SIZE_W'(pixel_y);
      wz_r <= '0;
      hz_r <= '0;
      xz_r <= '0;
      yz_r <= '0;
    end else if (cmd.sp_step) begin
      sw_r <= sw_r << 1;
      sh_r <= sh_r << 1;
      sx_r <= sx_r << 1;
      sy_r <= sy_r << 1;
      wz_r <= (wz_r << 1) + (sw_r[SIZE_W-1] ? ACCW'(zoom) : '0);
      hz_r <= (hz_r << 1) + (sh_r[SIZE_W-1] ? ACCW'(zoom) : '0);
      xz_r <= (xz_r << 1) + (sx_r[SIZE_W-1] ? ACCW'(zoom) : '0);
      yz_r <= (yz_r << 1) + (sy_r[SIZE_W-1] ? ACCW'(zoom) : '0);
    end
    if (cmd.sp_sum) begin
      tx_r <= {{(SPW-OFF_W){offset_x[OFF_W-1]}}, offset_x}
              - {{(SPW-ACCW+1){1'b0}}, wz_r[ACCW-1:1]};
      ty_r <= {{(SPW-OFF_W){offset_y[OFF_W-1]}}, offset_y}
              - {{(SPW-ACCW+1){1'b0}}, hz_r[ACCW-1:1]};
    end
  end

  always_comb begin
    ux = tx_r + {{(SPW-ACCW){1'b0}}, xz_r};
    uy = ty_r + {{(SPW-ACCW){1'b0}}, yz_r};
    if ($signed(ux) > $signed(CMAX_E))      cr_nxt = CMAX;
    else if ($signed(ux) < $signed(CMIN_E)) cr_nxt = CMIN;
    else                                    cr_nxt = ux[W-1:0];
    if ($signed(uy) > $signed(CMAX_E))      ci_nxt = CMAX;
    else if ($signed(uy) < $signed(CMIN_E)) ci_nxt = CMIN;
    else                                    ci_nxt = uy[W-1:0];
  end

  always_comb begin
    case (cmd.op)
      OP_R2:   begin mul_a = zr_r;         mul_b = zr_r; end
      OP_I2:   begin mul_a = zi_r;         mul_b = zi_r; end
      OP_R3:   begin mul_a = r2_r;         mul_b = zr_r; end
      OP_I3:   begin mul_a = i2_r;         mul_b = zi_r; end
      OP_T1:   begin mul_a = triple(r2_r); mul_b = zi_r; end
      OP_T2:   begin mul_a = triple(zr_r); mul_b = i2_r; end
      default: begin mul_a = '0;           mul_b = '0;   end
    endcase
  end

  mbc_mul #(
    .COORD_WIDTH(COORD_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_mul (
    .clk  (clk),
    .rst_n(rst_n),
    .start(cmd.mul_start),
    .a    (mul_a),
    .b    (mul_b),
    .done (mul_done),
    .p    (mul_p)
  );

  always_ff @(posedge clk) begin
    if (cmd.sp_clamp) begin
      cr_r <= cr_nxt;
      ci_r <= ci_nxt;
      zr_r <= cr_nxt;
      zi_r <= ci_nxt;
    end else if (cmd.upd_z) begin
      zr_r <= sat_add(dr_r, cr_r);
      zi_r <= sat_add(di_r, ci_r);
    end
    if (cmd.upd_diff) begin
      dr_r <= sat_sub(r3_r, t2_r);
      di_r <= sat_sub(t1_r, i3_r);
    end
    if (cmd.mul_wr) begin
      case (cmd.op)
        OP_R2:   r2_r <= mul_p;
        OP_I2:   i2_r <= mul_p;
        OP_R3:   r3_r <= mul_p;
        OP_I3:   i3_r <= mul_p;
        OP_T1:   t1_r <= mul_p;
        OP_T2:   t2_r <= mul_p;
        default: ;
      endcase
    end
  end

  // squares are never negative, so the sum is exact unsigned
  assign mag2 = EW'(r2_r) + EW'(i2_r);

  assign status.mul_done = mul_done;
  assign status.escape   = (mag2 > FOUR);

endmodule

// File: sv/mbc_ctrl.sv
module mbc_ctrl import mbc_pkg::*; #(
  parameter int COUNT_WIDTH = DEF_COUNT_WIDTH
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic [ITER_W-1:0]      max_iter,
  input  mbc_status_t            status,
  output mbc_cmd_t               cmd,
  output logic                   busy,
  output logic                   out_valid,
  output logic [COUNT_WIDTH-1:0] out_count
);

  localparam int RW   = (ITER_W > COUNT_WIDTH) ? ITER_W : COUNT_WIDTH;
  localparam int SPCW = $clog2(SIZE_W);
  localparam logic [SPCW-1:0] SP_LAST = SPCW'(SIZE_W - 1);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_SP    = 4'd1;
  localparam logic [3:0] S_SUM   = 4'd2;
  localparam logic [3:0] S_CLAMP = 4'd3;
  localparam logic [3:0] S_ISSUE = 4'd4;
  localparam logic [3:0] S_WAIT  = 4'd5;
  localparam logic [3:0] S_CHECK = 4'd6;
  localparam logic [3:0] S_UPD1  = 4'd7;
  localparam logic [3:0] S_UPD2  = 4'd8;

  function automatic logic [COUNT_WIDTH-1:0] sat_cnt(input logic [ITER_W-1:0] v);
    logic [RW-1:0] e;
    e = RW'(v);
    if ((e >> COUNT_WIDTH) != '0) return '1;
    return e[COUNT_WIDTH-1:0];
  endfunction

  logic [3:0]             state_r, state_nxt;
  logic [SPCW-1:0]        sp_cnt_r, sp_cnt_nxt;
  logic [OP_W-1:0]        op_r, op_nxt;
  logic [ITER_W-1:0]      n_r, n_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [COUNT_WIDTH-1:0] out_count_r, out_count_nxt;
  logic [ITER_W:0]        n_inc;

  assign n_inc = {1'b0, n_r} + (ITER_W+1)'(1);

  always_comb begin
    state_nxt     = state_r;
    sp_cnt_nxt    = sp_cnt_r;
    op_nxt        = op_r;
    n_nxt         = n_r;
    out_valid_nxt = 1'b0;
    out_count_nxt = out_count_r;
    cmd           = '0;
    cmd.op        = op_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          sp_cnt_nxt = '0;
          state_nxt  = S_SP;
        end
      end
      S_SP: begin
        cmd.sp_step = 1'b1;
        sp_cnt_nxt  = sp_cnt_r + SPCW'(1);
        if (sp_cnt_r == SP_LAST) state_nxt = S_SUM;
      end
      S_SUM: begin
        cmd.sp_sum = 1'b1;
        state_nxt  = S_CLAMP;
      end
      S_CLAMP: begin
        cmd.sp_clamp = 1'b1;
        n_nxt        = '0;
        op_nxt       = OP_R2;
        if (max_iter == '0) begin
          out_valid_nxt = 1'b1;
          out_count_nxt = '0;
          state_nxt     = S_IDLE;
        end else begin
          state_nxt = S_ISSUE;
        end
      end
      S_ISSUE: begin
        cmd.mul_start = 1'b1;
        state_nxt     = S_WAIT;
      end
      S_WAIT: begin
        if (status.mul_done) begin
          cmd.mul_wr = 1'b1;
          if (op_r == OP_I2) begin
            state_nxt = S_CHECK;
          end else if (op_r == OP_T2) begin
            state_nxt = S_UPD1;
          end else begin
            op_nxt    = op_r + OP_W'(1);
            state_nxt = S_ISSUE;
          end
        end
      end
      S_CHECK: begin
        // escape is judged on the z from before this step's update
        if (status.escape) begin
          out_valid_nxt = 1'b1;
          out_count_nxt = sat_cnt(n_r);
          state_nxt     = S_IDLE;
        end else begin
          op_nxt    = OP_R3;
          state_nxt = S_ISSUE;
        end
      end
      S_UPD1: begin
        cmd.upd_diff = 1'b1;
        state_nxt    = S_UPD2;
      end
      S_UPD2: begin
        cmd.upd_z = 1'b1;
        if (n_inc >= {1'b0, max_iter}) begin
          out_valid_nxt = 1'b1;
          out_count_nxt = sat_cnt(max_iter - ITER_W'(1));
          state_nxt     = S_IDLE;
        end else begin
          n_nxt     = n_inc[ITER_W-1:0];
          op_nxt    = OP_R2;
          state_nxt = S_ISSUE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    sp_cnt_r    <= sp_cnt_nxt;
    op_r        <= op_nxt;
    n_r         <= n_nxt;
    out_count_r <= out_count_nxt;
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_count = out_count_r;

endmodule
